// ===== rtl/core/mzf_pkg.sv =====
package mzf_pkg;

   localparam int STATE_FRAC_BITS = 24;
   localparam int SAMPLE_BITS     = 24;
   localparam int VAL_BITS        = 64;
   localparam int MUL_STEPS       = 34;
   localparam int DIV_STEPS       = 64;
   localparam int NREG            = 13;

   localparam logic signed [VAL_BITS-1:0] ONE_Q  = 64'sd1 <<< STATE_FRAC_BITS;
   localparam logic signed [VAL_BITS-1:0] THREE_Q = 64'sd3 <<< STATE_FRAC_BITS;
   localparam logic signed [VAL_BITS-1:0] C27_Q  = 64'sd27 <<< STATE_FRAC_BITS;

   localparam logic [16:0] Q16_ONE   = 17'd65536;
   localparam logic [16:0] Q16_HALF  = 17'd32768;
   localparam logic [15:0] GAIN_MIN  = 16'd7;
   localparam logic [15:0] GAIN_MAX  = 16'd65405;
   localparam logic [15:0] GAIN_RST  = 16'd6554;
   localparam int K_LADDER  = 258867;
   localparam int K_SALLEN  = 163840;
   localparam int K_CASCADE = 62915;
   localparam int K_SVF     = 63570;
   localparam int K_SPREAD  = 47186;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_MODEL = 3'd0,
      CSR_GAIN  = 3'd1,
      CSR_KNOB  = 3'd2,
      CSR_MORPH = 3'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      MDL_LADDER  = 2'd0,
      MDL_SALLEN  = 2'd1,
      MDL_CASCADE = 2'd2,
      MDL_SVF     = 2'd3
   } model_type;

   typedef enum logic [3:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_MULQ, OP_MULF, OP_DIV, OP_CLAMP, OP_SELM, OP_END
   } op_type;

   // operand sources: working registers below 16, derived constants from 16 up
   typedef enum logic [4:0] {
      R_X = 5'd0, R_S0 = 5'd1, R_S1 = 5'd2, R_S2 = 5'd3, R_S3 = 5'd4,
      R_RES = 5'd5, R_D = 5'd6, R_T = 5'd7, R_U = 5'd8, R_V = 5'd9,
      R_HP = 5'd10, R_BP = 5'd11, R_Y = 5'd12,
      C_G = 5'd16, C_K = 5'd17, C_M = 5'd18, C_ONE16 = 5'd19, C_TWO16 = 5'd20,
      C_HALF = 5'd21, C_NINE = 5'd22, C_C27 = 5'd23, C_KLAD = 5'd24,
      C_KSAL = 5'd25, C_KCAS = 5'd26, C_KSVF = 5'd27, C_KSPR = 5'd28
   } src_type;

   typedef struct packed {
      op_type  op;
      src_type dst;
      src_type a;
      src_type b;
   } uop_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH_A, ST_FETCH_B, ST_START, ST_WAIT, ST_CHECK
   } st_type;

   localparam logic [7:0] PC_LADDER  = 8'd0;
   localparam logic [7:0] PC_SALLEN  = 8'd55;
   localparam logic [7:0] PC_CASCADE = 8'd82;
   localparam logic [7:0] PC_SVF     = 8'd103;

   function automatic uop_type mk(input op_type op, input src_type d,
                                  input src_type a, input src_type b);
      uop_type u;
      u.op  = op;
      u.dst = d;
      u.a   = a;
      u.b   = b;
      return u;
   endfunction

   function automatic logic [7:0] start_pc(input logic [1:0] model);
      logic [7:0] p;
      case (model)
         MDL_LADDER:  p = PC_LADDER;
         MDL_SALLEN:  p = PC_SALLEN;
         MDL_CASCADE: p = PC_CASCADE;
         MDL_SVF:     p = PC_SVF;
         default:     p = PC_LADDER;
      endcase
      return p;
   endfunction

   // Microprogram. Saturator on T uses U and V as scratch.
   function automatic uop_type prog_rom(input logic [7:0] pc);
      uop_type u;
      case (pc)
         // four-pole ladder
         8'd0:   u = mk(OP_MULQ, R_RES, C_K, C_KLAD);
         8'd1:   u = mk(OP_MULQ, R_T, R_S3, R_RES);
         8'd2:   u = mk(OP_MULF, R_U, R_T, R_T);
         8'd3:   u = mk(OP_MUL, R_V, R_U, C_NINE);
         8'd4:   u = mk(OP_ADD, R_V, R_V, C_C27);
         8'd5:   u = mk(OP_ADD, R_U, R_U, C_C27);
         8'd6:   u = mk(OP_MUL, R_U, R_U, R_T);
         8'd7:   u = mk(OP_DIV, R_U, R_U, R_V);
         8'd8:   u = mk(OP_CLAMP, R_T, R_T, R_U);
         8'd9:   u = mk(OP_SUB, R_T, R_X, R_T);
         8'd10:  u = mk(OP_MULF, R_U, R_T, R_T);
         8'd11:  u = mk(OP_MUL, R_V, R_U, C_NINE);
         8'd12:  u = mk(OP_ADD, R_V, R_V, C_C27);
         8'd13:  u = mk(OP_ADD, R_U, R_U, C_C27);
         8'd14:  u = mk(OP_MUL, R_U, R_U, R_T);
         8'd15:  u = mk(OP_DIV, R_U, R_U, R_V);
         8'd16:  u = mk(OP_CLAMP, R_T, R_T, R_U);
         8'd17:  u = mk(OP_SUB, R_V, R_T, R_S0);
         8'd18:  u = mk(OP_MULQ, R_V, R_V, C_G);
         8'd19:  u = mk(OP_ADD, R_T, R_V, R_S0);
         8'd20:  u = mk(OP_ADD, R_S0, R_T, R_V);
         8'd21:  u = mk(OP_MULF, R_U, R_T, R_T);
         8'd22:  u = mk(OP_MUL, R_V, R_U, C_NINE);
         8'd23:  u = mk(OP_ADD, R_V, R_V, C_C27);
         8'd24:  u = mk(OP_ADD, R_U, R_U, C_C27);
         8'd25:  u = mk(OP_MUL, R_U, R_U, R_T);
         8'd26:  u = mk(OP_DIV, R_U, R_U, R_V);
         8'd27:  u = mk(OP_CLAMP, R_T, R_T, R_U);
         8'd28:  u = mk(OP_SUB, R_V, R_T, R_S1);
         8'd29:  u = mk(OP_MULQ, R_V, R_V, C_G);
         8'd30:  u = mk(OP_ADD, R_T, R_V, R_S1);
         8'd31:  u = mk(OP_ADD, R_S1, R_T, R_V);
         8'd32:  u = mk(OP_MULF, R_U, R_T, R_T);
         8'd33:  u = mk(OP_MUL, R_V, R_U, C_NINE);
         8'd34:  u = mk(OP_ADD, R_V, R_V, C_C27);
         8'd35:  u = mk(OP_ADD, R_U, R_U, C_C27);
         8'd36:  u = mk(OP_MUL, R_U, R_U, R_T);
         8'd37:  u = mk(OP_DIV, R_U, R_U, R_V);
         8'd38:  u = mk(OP_CLAMP, R_T, R_T, R_U);
         8'd39:  u = mk(OP_SUB, R_V, R_T, R_S2);
         8'd40:  u = mk(OP_MULQ, R_V, R_V, C_G);
         8'd41:  u = mk(OP_ADD, R_T, R_V, R_S2);
         8'd42:  u = mk(OP_ADD, R_S2, R_T, R_V);
         8'd43:  u = mk(OP_MULF, R_U, R_T, R_T);
         8'd44:  u = mk(OP_MUL, R_V, R_U, C_NINE);
         8'd45:  u = mk(OP_ADD, R_V, R_V, C_C27);
         8'd46:  u = mk(OP_ADD, R_U, R_U, C_C27);
         8'd47:  u = mk(OP_MUL, R_U, R_U, R_T);
         8'd48:  u = mk(OP_DIV, R_U, R_U, R_V);
         8'd49:  u = mk(OP_CLAMP, R_T, R_T, R_U);
         8'd50:  u = mk(OP_SUB, R_V, R_T, R_S3);
         8'd51:  u = mk(OP_MULQ, R_V, R_V, C_G);
         8'd52:  u = mk(OP_ADD, R_Y, R_V, R_S3);
         8'd53:  u = mk(OP_ADD, R_S3, R_Y, R_V);
         8'd54:  u = mk(OP_END, R_X, R_X, R_X);
         // two-pole with saturated feedback
         8'd55:  u = mk(OP_MULQ, R_RES, C_K, C_KSAL);
         8'd56:  u = mk(OP_MULQ, R_T, R_S1, R_RES);
         8'd57:  u = mk(OP_MULF, R_U, R_T, R_T);
         8'd58:  u = mk(OP_MUL, R_V, R_U, C_NINE);
         8'd59:  u = mk(OP_ADD, R_V, R_V, C_C27);
         8'd60:  u = mk(OP_ADD, R_U, R_U, C_C27);
         8'd61:  u = mk(OP_MUL, R_U, R_U, R_T);
         8'd62:  u = mk(OP_DIV, R_U, R_U, R_V);
         8'd63:  u = mk(OP_CLAMP, R_T, R_T, R_U);
         8'd64:  u = mk(OP_ADD, R_U, C_G, C_TWO16);
         8'd65:  u = mk(OP_MULQ, R_D, R_U, C_G);
         8'd66:  u = mk(OP_ADD, R_D, R_D, C_ONE16);
         8'd67:  u = mk(OP_ADD, R_U, C_G, C_G);
         8'd68:  u = mk(OP_ADD, R_U, R_U, C_ONE16);
         8'd69:  u = mk(OP_MULQ, R_U, R_S0, R_U);
         8'd70:  u = mk(OP_SUB, R_V, R_X, R_T);
         8'd71:  u = mk(OP_SUB, R_V, R_V, R_U);
         8'd72:  u = mk(OP_SUB, R_V, R_V, R_S1);
         8'd73:  u = mk(OP_MUL, R_V, R_V, C_ONE16);
         8'd74:  u = mk(OP_DIV, R_HP, R_V, R_D);
         8'd75:  u = mk(OP_MULQ, R_U, R_HP, C_G);
         8'd76:  u = mk(OP_ADD, R_BP, R_U, R_S0);
         8'd77:  u = mk(OP_ADD, R_S0, R_BP, R_U);
         8'd78:  u = mk(OP_MULQ, R_U, R_BP, C_G);
         8'd79:  u = mk(OP_ADD, R_Y, R_U, R_S1);
         8'd80:  u = mk(OP_ADD, R_S1, R_Y, R_U);
         8'd81:  u = mk(OP_END, R_X, R_X, R_X);
         // linear cascade, last pole scaled
         8'd82:  u = mk(OP_MULQ, R_RES, C_K, C_KCAS);
         8'd83:  u = mk(OP_MULQ, R_D, C_G, C_KSPR);
         8'd84:  u = mk(OP_MULQ, R_T, R_S3, R_RES);
         8'd85:  u = mk(OP_SUB, R_T, R_X, R_T);
         8'd86:  u = mk(OP_SUB, R_V, R_T, R_S0);
         8'd87:  u = mk(OP_MULQ, R_V, R_V, C_G);
         8'd88:  u = mk(OP_ADD, R_T, R_V, R_S0);
         8'd89:  u = mk(OP_ADD, R_S0, R_T, R_V);
         8'd90:  u = mk(OP_SUB, R_V, R_T, R_S1);
         8'd91:  u = mk(OP_MULQ, R_V, R_V, C_G);
         8'd92:  u = mk(OP_ADD, R_T, R_V, R_S1);
         8'd93:  u = mk(OP_ADD, R_S1, R_T, R_V);
         8'd94:  u = mk(OP_SUB, R_V, R_T, R_S2);
         8'd95:  u = mk(OP_MULQ, R_V, R_V, C_G);
         8'd96:  u = mk(OP_ADD, R_T, R_V, R_S2);
         8'd97:  u = mk(OP_ADD, R_S2, R_T, R_V);
         8'd98:  u = mk(OP_SUB, R_V, R_T, R_S3);
         8'd99:  u = mk(OP_MULQ, R_V, R_V, R_D);
         8'd100: u = mk(OP_ADD, R_Y, R_V, R_S3);
         8'd101: u = mk(OP_ADD, R_S3, R_Y, R_V);
         8'd102: u = mk(OP_END, R_X, R_X, R_X);
         // state-variable with output morph
         8'd103: u = mk(OP_MULQ, R_U, C_K, C_KSVF);
         8'd104: u = mk(OP_SUB, R_U, C_ONE16, R_U);
         8'd105: u = mk(OP_ADD, R_U, R_U, R_U);
         8'd106: u = mk(OP_ADD, R_U, R_U, C_G);
         8'd107: u = mk(OP_MULQ, R_D, C_G, R_U);
         8'd108: u = mk(OP_ADD, R_D, R_D, C_ONE16);
         8'd109: u = mk(OP_MULQ, R_V, R_S0, R_U);
         8'd110: u = mk(OP_SUB, R_V, R_X, R_V);
         8'd111: u = mk(OP_SUB, R_V, R_V, R_S1);
         8'd112: u = mk(OP_MUL, R_V, R_V, C_ONE16);
         8'd113: u = mk(OP_DIV, R_HP, R_V, R_D);
         8'd114: u = mk(OP_MULQ, R_U, R_HP, C_G);
         8'd115: u = mk(OP_ADD, R_BP, R_U, R_S0);
         8'd116: u = mk(OP_ADD, R_S0, R_U, R_BP);
         8'd117: u = mk(OP_MULQ, R_U, R_BP, C_G);
         8'd118: u = mk(OP_ADD, R_Y, R_U, R_S1);
         8'd119: u = mk(OP_ADD, R_S1, R_U, R_Y);
         8'd120: u = mk(OP_ADD, R_T, C_M, C_M);
         8'd121: u = mk(OP_MULQ, R_T, R_HP, R_T);
         8'd122: u = mk(OP_ADD, R_T, R_Y, R_T);
         8'd123: u = mk(OP_SUB, R_U, C_M, C_HALF);
         8'd124: u = mk(OP_ADD, R_U, R_U, R_U);
         8'd125: u = mk(OP_MULQ, R_U, R_Y, R_U);
         8'd126: u = mk(OP_ADD, R_V, R_Y, R_HP);
         8'd127: u = mk(OP_SUB, R_V, R_V, R_U);
         8'd128: u = mk(OP_SELM, R_Y, R_T, R_V);
         default: u = mk(OP_END, R_X, R_X, R_X);
      endcase
      return u;
   endfunction

endpackage

// ===== rtl/core/mzf_alu.sv =====
module mzf_alu (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  mzf_pkg::op_type                    op,
   input  logic signed [mzf_pkg::VAL_BITS-1:0] opa,
   input  logic signed [mzf_pkg::VAL_BITS-1:0] opb,
   output logic                               done,
   output logic signed [mzf_pkg::VAL_BITS-1:0] result
);
   import mzf_pkg::*;

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   op_type                     op_ff, op_in;
   logic [5:0]                 cnt_ff, cnt_in;
   logic signed [VAL_BITS-1:0] acc_ff, acc_in;
   logic signed [VAL_BITS-1:0] mcand_ff, mcand_in;
   logic [MUL_STEPS-1:0]       mplier_ff, mplier_in;
   logic [VAL_BITS-1:0]        rem_ff, rem_in;
   logic [VAL_BITS-1:0]        quo_ff, quo_in;
   logic [VAL_BITS-1:0]        dvs_ff, dvs_in;
   logic                       neg_ff, neg_in;
   logic signed [VAL_BITS-1:0] result_ff, result_in;
   logic signed [VAL_BITS-1:0] sum;
   logic [VAL_BITS-1:0]        rem_sh;

   assign done   = done_ff;
   assign result = result_ff;

   // one unit serves add, subtract, clamp, shift-add multiply and restoring divide
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      result_in = result_ff;
      sum       = acc_ff;
      rem_sh    = {rem_ff[VAL_BITS-2:0], quo_ff[VAL_BITS-1]};
      if (start) begin
         op_in  = op;
         cnt_in = '0;
         case (op)
            OP_ADD: begin
               result_in = opa + opb;
               done_in   = 1'b1;
            end
            OP_SUB: begin
               result_in = opa - opb;
               done_in   = 1'b1;
            end
            OP_CLAMP: begin
               if (opa >= THREE_Q)       result_in = ONE_Q;
               else if (opa <= -THREE_Q) result_in = -ONE_Q;
               else                      result_in = opb;
               done_in = 1'b1;
            end
            OP_MUL, OP_MULQ, OP_MULF: begin
               acc_in    = '0;
               mcand_in  = opa;
               mplier_in = opb[MUL_STEPS-1:0];
               busy_in   = 1'b1;
            end
            OP_DIV: begin
               rem_in  = '0;
               quo_in  = opa[VAL_BITS-1] ? -opa : opa;
               dvs_in  = opb[VAL_BITS-1] ? -opb : opb;
               neg_in  = opa[VAL_BITS-1] ^ opb[VAL_BITS-1];
               busy_in = 1'b1;
            end
            default: begin
               result_in = '0;
               done_in   = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 6'd1;
         case (op_ff)
            OP_DIV: begin
               // one quotient bit per cycle
               if (rem_sh >= dvs_ff) begin
                  rem_in = rem_sh - dvs_ff;
                  quo_in = {quo_ff[VAL_BITS-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  quo_in = {quo_ff[VAL_BITS-2:0], 1'b0};
               end
               if (cnt_ff == 6'(DIV_STEPS - 1)) begin
                  busy_in   = 1'b0;
                  done_in   = 1'b1;
                  result_in = neg_ff ? -$signed(quo_in) : $signed(quo_in);
               end
            end
            default: begin
               // top multiplier bit carries negative weight
               if (mplier_ff[0]) begin
                  if (cnt_ff == 6'(MUL_STEPS - 1)) sum = acc_ff - mcand_ff;
                  else                              sum = acc_ff + mcand_ff;
               end
               acc_in    = sum;
               mcand_in  = mcand_ff <<< 1;
               mplier_in = mplier_ff >> 1;
               if (cnt_ff == 6'(MUL_STEPS - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  case (op_ff)
                     OP_MULQ: result_in = (sum + 64'sd32768) >>> 16;
                     OP_MULF: result_in = (sum + (64'sd1 <<< (STATE_FRAC_BITS - 1)))
                                          >>> STATE_FRAC_BITS;
                     default: result_in = sum;
                  endcase
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_ADD;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("alu started while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("alu done while still busy");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff && op_ff != OP_DIV |-> cnt_ff < 6'(MUL_STEPS))
      else $error("multiply ran past its step count");

endmodule

// ===== rtl/core/multimode_zdf_filter.sv =====
// Zero-delay-feedback audio filter with four models (ladder, two-pole with
// saturated feedback, spread-pole cascade, state-variable with morph). One
// sample goes in, one filtered sample comes out; internal values are Q40.24.
// All arithmetic runs on one shared unit under a microprogram: a multiply
// takes 34 shift-add steps and a divide 64 restoring steps. An item ends
// only once the output register is free to take its result.
// req_tready is low while an item is worked on; a finished result waits in an
// output register. Configuration writes are taken at any time but must only
// be made while no item is in flight.
module multimode_zdf_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mzf_pkg::SAMPLE_BITS-1:0]      req_tdata,  // sample_in
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mzf_pkg::SAMPLE_BITS-1:0]      rsp_tdata,  // sample_out
   output logic                                 rsp_tuser,  // state_cleared
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [2:0]                           csr_index,
   input  logic [16:0]                          csr_data
);
   import mzf_pkg::*;

   localparam int IN_SHIFT = STATE_FRAC_BITS - (SAMPLE_BITS - 1);
   localparam logic signed [VAL_BITS-1:0] SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam logic signed [VAL_BITS-1:0] SMIN = -(64'sd1 <<< (SAMPLE_BITS - 1));
   localparam logic signed [VAL_BITS-1:0] Y_HALF = 64'sd1 <<< (IN_SHIFT - 1);

   logic [1:0]                 model_ff;
   logic [15:0]                gain_ff;
   logic [16:0]                knob_ff, morph_ff;
   st_type                     st_ff, st_in;
   logic [7:0]                 pc_ff;
   logic signed [VAL_BITS-1:0] rf_ff [NREG];
   logic signed [VAL_BITS-1:0] opa_ff, opb_ff;
   logic                       rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]     rsp_data_ff;
   logic                       rsp_user_ff;

   uop_type                    uop;
   logic                       accept, slot_free, alu_start, alu_done, bad, m_low;
   logic signed [VAL_BITS-1:0] alu_result, src_val, y_val;
   logic [15:0]                g_clamp;
   logic [16:0]                k_clamp, m_clamp;
   logic [SAMPLE_BITS-1:0]     y_sat;

   assign uop       = prog_rom(pc_ff);
   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // clamp configuration into range
   always_comb begin
      if (gain_ff < GAIN_MIN)      g_clamp = GAIN_MIN;
      else if (gain_ff > GAIN_MAX) g_clamp = GAIN_MAX;
      else                         g_clamp = gain_ff;
      k_clamp = (knob_ff > Q16_ONE) ? Q16_ONE : knob_ff;
      m_clamp = (morph_ff > Q16_ONE) ? Q16_ONE : morph_ff;
      m_low   = (m_clamp <= Q16_HALF);
   end

   // operand fetch: one working register or one constant per cycle
   always_comb begin
      src_val = '0;
      if (!uop.a[4] && st_ff == ST_FETCH_A) src_val = rf_ff[uop.a[3:0]];
      else if (!uop.b[4] && st_ff == ST_FETCH_B) src_val = rf_ff[uop.b[3:0]];
      else begin
         case ((st_ff == ST_FETCH_A) ? uop.a : uop.b)
            C_G:     src_val = 64'(g_clamp);
            C_K:     src_val = 64'(k_clamp);
            C_M:     src_val = 64'(m_clamp);
            C_ONE16: src_val = 64'(Q16_ONE);
            C_TWO16: src_val = 64'sd131072;
            C_HALF:  src_val = 64'(Q16_HALF);
            C_NINE:  src_val = 64'sd9;
            C_C27:   src_val = C27_Q;
            C_KLAD:  src_val = 64'(K_LADDER);
            C_KSAL:  src_val = 64'(K_SALLEN);
            C_KCAS:  src_val = 64'(K_CASCADE);
            C_KSVF:  src_val = 64'(K_SVF);
            C_KSPR:  src_val = 64'(K_SPREAD);
            default: src_val = '0;
         endcase
      end
   end

   // overflow check, rounding back to sample scale and output saturation
   always_comb begin
      bad = 1'b0;
      for (int i = 1; i <= 4; i++) begin
         if (rf_ff[i][VAL_BITS-1:31] != '0 && rf_ff[i][VAL_BITS-1:31] != '1) bad = 1'b1;
      end
      y_val = (rf_ff[R_Y[3:0]] + Y_HALF) >>> IN_SHIFT;
      if (y_val > SMAX)      y_sat = SMAX[SAMPLE_BITS-1:0];
      else if (y_val < SMIN) y_sat = SMIN[SAMPLE_BITS-1:0];
      else                   y_sat = y_val[SAMPLE_BITS-1:0];
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE:    if (accept) st_in = ST_FETCH_A;
         ST_FETCH_A: st_in = (uop.op == OP_END) ? ST_CHECK : ST_FETCH_B;
         ST_FETCH_B: st_in = ST_START;
         ST_START:   st_in = (uop.op == OP_SELM) ? ST_FETCH_A : ST_WAIT;
         ST_WAIT:    if (alu_done) st_in = ST_FETCH_A;
         ST_CHECK:   if (slot_free) st_in = ST_IDLE;
         default:    st_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = (st_ff == ST_IDLE);
      alu_start  = (st_ff == ST_START) && (uop.op != OP_SELM);
   end

   mzf_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .start  (alu_start),
      .op     (uop.op),
      .opa    (opa_ff),
      .opb    (opb_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         pc_ff        <= '0;
         model_ff     <= MDL_LADDER;
         gain_ff      <= GAIN_RST;
         knob_ff      <= Q16_HALF;
         morph_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NREG; i++) rf_ff[i] <= '0;
      end else begin
         st_ff <= st_in;
         // configuration writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODEL: model_ff <= csr_data[1:0];
               CSR_GAIN:  gain_ff  <= csr_data[15:0];
               CSR_KNOB:  knob_ff  <= csr_data;
               CSR_MORPH: morph_ff <= csr_data;
               default:   ;
            endcase
         end
         // load input scaled to state format, advance program
         if (accept) begin
            rf_ff[R_X[3:0]] <= 64'(signed'(req_tdata)) <<< IN_SHIFT;
            pc_ff <= start_pc(model_ff);
         end
         if (st_ff == ST_START && uop.op == OP_SELM) begin
            rf_ff[uop.dst[3:0]] <= m_low ? opa_ff : opb_ff;
            pc_ff <= pc_ff + 8'd1;
         end
         if (st_ff == ST_WAIT && alu_done) begin
            rf_ff[uop.dst[3:0]] <= alu_result;
            pc_ff <= pc_ff + 8'd1;
         end
         // deliver result, clear state on overflow
         if (st_ff == ST_CHECK && slot_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_user_ff  <= bad;
            rsp_data_ff  <= bad ? '0 : y_sat;
            if (bad) begin
               for (int i = 1; i <= 4; i++) rf_ff[i] <= '0;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (st_ff == ST_FETCH_A) opa_ff <= src_val;
      if (st_ff == ST_FETCH_B) opb_ff <= src_val;
   end

   a_accept_fetch: assert property (@(posedge clock) disable iff (reset)
      accept |=> st_ff == ST_FETCH_A) else $error("accepted item not started");
   a_cleared_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff |-> rsp_data_ff == '0)
      else $error("cleared state with nonzero output");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> st_ff == ST_WAIT) else $error("alu result outside wait");
   a_clear_state: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_CHECK && slot_free && bad |=> rf_ff[R_S3[3:0]] == '0)
      else $error("overflow did not clear state");

endmodule

// ===== tb/multimode_zdf_filter_tb.sv =====
`default_nettype none

module multimode_zdf_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mzf_pkg::*;

   localparam logic [2:0] CSR_UNUSED = 3'd5;
   localparam int         IDLE_LIMIT = 20000;
   localparam int         RANDOM_ITEMS = 2000;

   typedef enum logic {ROW_CSR, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [2:0]   idx;
      logic [23:0]  data;
      bit           typed;
      logic [23:0]  exp_sample;
      logic         exp_cleared;
   } plan_row_type;

   typedef struct {
      logic [23:0] sample;
      logic        cleared;
   } filt_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [16:0] csr_data = '0;

   // predictor copy of configuration and integrator state
   logic [1:0]  cur_model;
   logic [15:0] cur_gain;
   logic [16:0] cur_knob;
   logic [16:0] cur_morph;
   longint      integ [4];

   filt_out_type expected_outs[$];
   plan_row_type plan[$];
   int          errors = 0;
   int          outputs_seen = 0;
   int          clears_seen = 0;
   int          idle_cycles = 0;
   bit          no_gaps = 1'b0;
   bit [3:0]    models_used = '0;

   multimode_zdf_filter dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint rshr(input longint v, input int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint mulq(input longint a, input longint c);
      return rshr(a * c, 16);
   endfunction

   function automatic longint soft_clip(input longint x);
      longint one, x2;
      one = 64'sd1 <<< 24;
      if (x >= 3 * one) return one;
      if (x <= -3 * one) return -one;
      x2 = rshr(x * x, 24);
      return (x * (27 * one + x2)) / (27 * one + 9 * x2);
   endfunction

   function automatic longint integrate(input longint inp, inout longint s, input longint g);
      longint v, y;
      v = mulq(inp - s, g);
      y = v + s;
      s = y + v;
      return y;
   endfunction

   // compute one filtered sample and advance the integrator state
   function automatic filt_out_type filter_sample(input logic [23:0] din);
      filt_out_type r;
      longint g, k, m, x, y, res, d, hp, bp, lp, fb, t, g4, rr, k2;
      longint s [4];
      bit ovf;
      g = (cur_gain < GAIN_MIN) ? GAIN_MIN : (cur_gain > GAIN_MAX) ? GAIN_MAX : cur_gain;
      k = (cur_knob > 65536) ? 65536 : cur_knob;
      m = (cur_morph > 65536) ? 65536 : cur_morph;
      x = longint'($signed(din)) * 2;
      s = integ;
      case (model_type'(cur_model))
         MDL_SALLEN: begin
            res = (k * K_SALLEN + 32768) >>> 16;
            fb = soft_clip(mulq(s[1], res));
            d = 65536 + ((g * (131072 + g) + 32768) >>> 16);
            hp = ((x - fb - mulq(s[0], 2 * g + 65536) - s[1]) * 65536) / d;
            bp = mulq(hp, g) + s[0];
            s[0] = bp + mulq(hp, g);
            lp = mulq(bp, g) + s[1];
            s[1] = lp + mulq(bp, g);
            y = lp;
         end
         MDL_CASCADE: begin
            g4 = (g * K_SPREAD + 32768) >>> 16;
            res = (k * K_CASCADE + 32768) >>> 16;
            t = x - mulq(s[3], res);
            t = integrate(t, s[0], g);
            t = integrate(t, s[1], g);
            t = integrate(t, s[2], g);
            y = integrate(t, s[3], g4);
         end
         MDL_SVF: begin
            rr = 65536 - ((k * K_SVF + 32768) >>> 16);
            k2 = 2 * rr + g;
            d = 65536 + ((g * k2 + 32768) >>> 16);
            hp = ((x - mulq(s[0], k2) - s[1]) * 65536) / d;
            bp = mulq(hp, g) + s[0];
            s[0] = mulq(hp, g) + bp;
            lp = mulq(bp, g) + s[1];
            s[1] = mulq(bp, g) + lp;
            if (m <= 32768) y = lp + mulq(hp, 2 * m);
            else y = lp + hp - mulq(lp, 2 * (m - 32768));
         end
         default: begin
            res = (k * K_LADDER + 32768) >>> 16;
            fb = soft_clip(mulq(s[3], res));
            t = soft_clip(x - fb);
            t = soft_clip(integrate(t, s[0], g));
            t = soft_clip(integrate(t, s[1], g));
            t = soft_clip(integrate(t, s[2], g));
            y = integrate(t, s[3], g);
         end
      endcase
      ovf = 1'b0;
      foreach (s[i])
         if (s[i] > 64'sd2147483647 || s[i] < -64'sd2147483648) ovf = 1'b1;
      if (ovf) begin
         integ = '{0, 0, 0, 0};
         r.sample = '0;
         r.cleared = 1'b1;
         return r;
      end
      integ = s;
      y = rshr(y, 1);
      if (y > 64'sd8388607) y = 64'sd8388607;
      if (y < -64'sd8388608) y = -64'sd8388608;
      r.sample = y[23:0];
      r.cleared = 1'b0;
      return r;
   endfunction

   function automatic void apply_csr(input logic [2:0] idx, input logic [16:0] v);
      case (idx)
         CSR_MODEL: cur_model = v[1:0];
         CSR_GAIN:  cur_gain = v[15:0];
         CSR_KNOB:  cur_knob = v;
         CSR_MORPH: cur_morph = v;
         default: ;
      endcase
   endfunction

   // mostly short gaps, a few long ones, none during a burst
   function automatic int pick_gap();
      int p;
      if (no_gaps) return 0;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [16:0] v);
      req_tvalid <= 1'b0;
      while (expected_outs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, v);
      csr_valid <= 1'b0;
   endtask

   // keep valid up across an accept when the next item follows at once
   task automatic send_sample(input logic [23:0] v, input bit typed,
                              input filt_out_type typed_out);
      filt_out_type p;
      int           gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= v;
      do @(posedge clock); while (!req_tready);
      models_used[cur_model] = 1'b1;
      p = filter_sample(v);
      expected_outs.push_back(typed ? typed_out : p);
   endtask

   task automatic add_row(input row_kind_type kd, input logic [2:0] idx, input logic [23:0] v,
                          input bit typed, input logic [23:0] es, input logic ec);
      plan_row_type r;
      r.kind = kd; r.idx = idx; r.data = v; r.typed = typed;
      r.exp_sample = es; r.exp_cleared = ec;
      plan.push_back(r);
   endtask

   function automatic logic [23:0] random_sample();
      case ($urandom_range(0, 5))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($signed($urandom_range(0, 2047)) - 1024);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [16:0] random_field(input logic [2:0] idx);
      case ($urandom_range(0, 3))
         0: return (idx == CSR_GAIN) ? 17'd7 : 17'd0;
         1: return (idx == CSR_GAIN) ? 17'd65405 : 17'd65536;
         default: return 17'($urandom);
      endcase
   endfunction

   // check results against the oldest expectation
   always @(posedge clock) begin
      filt_out_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            outputs_seen++;
            if (rsp_tuser) clears_seen++;
            if (expected_outs.size() == 0) begin
               $display("%0t: unexpected item sample=%h cleared=%b", $time, rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               e = expected_outs.pop_front();
               if (rsp_tdata !== e.sample) begin
                  $display("%0t: sample_out expected %h actual %h", $time, e.sample, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser !== e.cleared) begin
                  $display("%0t: state_cleared expected %b actual %b", $time, e.cleared,
                           rsp_tuser);
                  errors++;
               end
            end
         end
         rsp_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) < 60);
      end
   end

   // toggle stretches with no idling on either side
   always @(posedge clock)
      if ($urandom_range(0, 499) == 0) no_gaps <= !no_gaps;

   // stop the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("multimode_zdf_filter test failed");
         $finish;
      end
   end

   initial begin
      filt_out_type t;
      logic [2:0]   ri;
      cur_model = MDL_LADDER;
      cur_gain = GAIN_RST;
      cur_knob = 17'd32768;
      cur_morph = 17'd0;
      integ = '{0, 0, 0, 0};

      // directed plan: silence after reset, extremes, clamps, every model and morph
      add_row(ROW_SAMPLE, 3'd0, 24'h000000, 1'b1, 24'h000000, 1'b0);
      add_row(ROW_SAMPLE, 3'd0, 24'h7FFFFF, 1'b0, 24'h0, 1'b0);
      add_row(ROW_SAMPLE, 3'd0, 24'h800000, 1'b0, 24'h0, 1'b0);
      add_row(ROW_CSR, CSR_GAIN, 24'd0, 1'b0, 24'h0, 1'b0);
      add_row(ROW_SAMPLE, 3'd0, 24'h7FFFFF, 1'b0, 24'h0, 1'b0);
      add_row(ROW_CSR, CSR_GAIN, 24'h1FFFF, 1'b0, 24'h0, 1'b0);
      add_row(ROW_CSR, CSR_KNOB, 24'h1FFFF, 1'b0, 24'h0, 1'b0);
      add_row(ROW_SAMPLE, 3'd0, 24'h7FFFFF, 1'b0, 24'h0, 1'b0);
      add_row(ROW_SAMPLE, 3'd0, 24'h800000, 1'b0, 24'h0, 1'b0);
      add_row(ROW_CSR, CSR_MODEL, 24'(MDL_SALLEN), 1'b0, 24'h0, 1'b0);
      add_row(ROW_SAMPLE, 3'd0, 24'h7FFFFF, 1'b0, 24'h0, 1'b0);
      add_row(ROW_SAMPLE, 3'd0, 24'h800000, 1'b0, 24'h0, 1'b0);
      add_row(ROW_CSR, CSR_MODEL, 24'(MDL_CASCADE), 1'b0, 24'h0, 1'b0);
      add_row(ROW_SAMPLE, 3'd0, 24'h7FFFFF, 1'b0, 24'h0, 1'b0);
      add_row(ROW_SAMPLE, 3'd0, 24'h800000, 1'b0, 24'h0, 1'b0);
      add_row(ROW_CSR, CSR_MODEL, 24'(MDL_SVF), 1'b0, 24'h0, 1'b0);
      add_row(ROW_SAMPLE, 3'd0, 24'h7FFFFF, 1'b0, 24'h0, 1'b0);
      add_row(ROW_CSR, CSR_MORPH, 24'd32768, 1'b0, 24'h0, 1'b0);
      add_row(ROW_SAMPLE, 3'd0, 24'h800000, 1'b0, 24'h0, 1'b0);
      add_row(ROW_CSR, CSR_MORPH, 24'd65536, 1'b0, 24'h0, 1'b0);
      add_row(ROW_SAMPLE, 3'd0, 24'h7FFFFF, 1'b0, 24'h0, 1'b0);
      add_row(ROW_CSR, CSR_MORPH, 24'h1FFFF, 1'b0, 24'h0, 1'b0);
      add_row(ROW_SAMPLE, 3'd0, 24'h800000, 1'b0, 24'h0, 1'b0);
      add_row(ROW_CSR, CSR_UNUSED, 24'h1FFFF, 1'b0, 24'h0, 1'b0);
      add_row(ROW_SAMPLE, 3'd0, 24'h123456, 1'b0, 24'h0, 1'b0);
      add_row(ROW_CSR, CSR_KNOB, 24'd0, 1'b0, 24'h0, 1'b0);
      add_row(ROW_CSR, CSR_MODEL, 24'(MDL_LADDER), 1'b0, 24'h0, 1'b0);
      add_row(ROW_SAMPLE, 3'd0, 24'h7FFFFF, 1'b0, 24'h0, 1'b0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) csr_write(plan[i].idx, plan[i].data[16:0]);
         else begin
            t.sample = plan[i].exp_sample;
            t.cleared = plan[i].exp_cleared;
            send_sample(plan[i].data, plan[i].typed, t);
         end
      end

      // random phases: fresh settings, then a burst of samples
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            csr_write(CSR_MODEL, 17'($urandom));
            csr_write(CSR_GAIN, random_field(CSR_GAIN));
            csr_write(CSR_KNOB, random_field(CSR_KNOB));
            csr_write(CSR_MORPH, random_field(CSR_MORPH));
            if ($urandom_range(0, 3) == 0) begin
               ri = 3'($urandom_range(4, 7));
               csr_write(ri, 17'($urandom));
            end
         end
         send_sample(random_sample(), 1'b0, t);
      end

      req_tvalid <= 1'b0;
      while (expected_outs.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Checked %0d filtered samples (%0d with cleared state), models seen mask %b.",
               outputs_seen, clears_seen, models_used);
      if (errors == 0)
         $display("multimode_zdf_filter test passed");
      else
         $display("multimode_zdf_filter test failed");
      $finish;
   end

endmodule

`default_nettype wire
